// File: hdl/scag_pkg.sv
// ----------------------------------------------------------------------------
// scag_pkg
// Types and constants for the sampled credit admission gate.
// ----------------------------------------------------------------------------
package scag_pkg;

   // request kinds
   localparam logic CMD_SUBMIT  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // verdict codes
   typedef logic [2:0] verdict_type;
   localparam verdict_type V_ACCEPTED      = 3'd0;
   localparam verdict_type V_UNAVAILABLE   = 3'd1;
   localparam verdict_type V_SAMPLED_OUT   = 3'd2;
   localparam verdict_type V_FULL          = 3'd3;
   localparam verdict_type V_RELEASED      = 3'd4;
   localparam verdict_type V_RELEASE_ERROR = 3'd5;

   // register indexes
   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type REG_MAX_MESSAGES  = 3'd0;
   localparam csr_addr_type REG_MAX_BYTES     = 3'd1;
   localparam csr_addr_type REG_SAMPLE_CUTOFF = 3'd2;
   localparam csr_addr_type REG_BLOCKED       = 3'd3;
   localparam csr_addr_type REG_OPEN          = 3'd4;

   // register reset values
   localparam logic [30:0] MAX_MESSAGES_RST  = 31'd1024;
   localparam logic [31:0] MAX_BYTES_RST     = 32'd1048576;
   localparam logic [63:0] SAMPLE_CUTOFF_RST = 64'hFFFF_FFFF_FFFF_FFFF;

   // splitmix64 constants
   localparam logic [63:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
   localparam int unsigned MIX_SHIFT_A = 30;
   localparam int unsigned MIX_SHIFT_B = 27;
   localparam int unsigned MIX_SHIFT_C = 31;

   // widths
   localparam int unsigned MSG_W  = 31;
   localparam int unsigned BYTE_W = 32;
   localparam int unsigned RSP_DATA_W = 72;

endpackage

// File: hdl/sampled_credit_admission_gate_unit.sv
// ----------------------------------------------------------------------------
// sampled_credit_admission_gate_unit
// Admission gate: samples submitted messages by a splitmix64 hash and reserves
// message and byte credit against programmable limits; releases return credit.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one request: tuser is the command (0 submit, 1 release),
//   tdata the message length in bytes. rsp_* returns exactly one result per
//   request: verdict, held messages and held bytes after the request.
//   csr_* writes the limits, the sample cutoff and the blocked/open flags;
//   write only while no request is in flight.
// sequencing:
//   a submission that needs a hash passes through two 64x64 multiplies
//   (three 32x32 partial products each on one shared multiplier) and three
//   shift/xor steps before the decision; any other request goes straight
//   to the decision. req_tready returns once the result is registered.
// reset: synchronous; credit and sequence counter clear, registers take their
//   defaults (gate closed). a stalled rsp holds its result; the next request
//   may be accepted meanwhile, but its result waits until rsp is taken.
// ----------------------------------------------------------------------------
module sampled_credit_admission_gate_unit
   import scag_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] message_bytes
   input  logic                  req_tuser,   // [0] command
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] verdict, [33:3] held_messages,
                                              // [65:34] held_bytes, [71:66] zero
   // configuration port
   input  logic                  csr_wen,
   input  csr_addr_type          csr_addr,
   input  logic [63:0]           csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_XFORM  = 2'd1;
   localparam logic [1:0] ST_MUL    = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   // configuration
   logic [MSG_W-1:0]  max_msgs_ff;
   logic [BYTE_W-1:0] max_bytes_ff;
   logic [63:0]       cutoff_ff;
   logic              blocked_ff;
   logic              open_ff;

   // state
   logic [63:0]       seq_ff, seq_in;
   logic [MSG_W-1:0]  credit_msgs_ff, credit_msgs_in;
   logic [BYTE_W-1:0] credit_bytes_ff, credit_bytes_in;

   // sequencer
   logic [1:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        step_ff, step_in;
   logic [63:0]       work_ff, work_in;
   logic [63:0]       opnd_ff, opnd_in;
   logic              cmd_ff, cmd_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic              unavail_ff, unavail_in;
   logic              pass_ff, pass_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] mul_k;
   logic [63:0] hash_val;
   logic        accept;
   logic        out_free;
   verdict_type verdict;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mul_k = (phase_ff == 2'd0) ? MIX_MUL_A : MIX_MUL_B;

   // partial products of the 64x64 product mod 2^64
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_a = opnd_ff[31:0];
            mul_b = mul_k[31:0];
         end
         2'd1: begin
            mul_a = opnd_ff[63:32];
            mul_b = mul_k[31:0];
         end
         default: begin
            mul_a = opnd_ff[31:0];
            mul_b = mul_k[63:32];
         end
      endcase
   end
   assign mul_p    = {32'b0, mul_a} * {32'b0, mul_b};
   assign hash_val = work_ff ^ (work_ff >> MIX_SHIFT_C);

   // credit decision
   always_comb begin
      credit_msgs_in  = credit_msgs_ff;
      credit_bytes_in = credit_bytes_ff;
      if (cmd_ff == CMD_RELEASE) begin
         if (credit_msgs_ff == '0 || credit_bytes_ff < len_ff) begin
            verdict = V_RELEASE_ERROR;
         end else begin
            verdict         = V_RELEASED;
            credit_msgs_in  = credit_msgs_ff - MSG_W'(1);
            credit_bytes_in = credit_bytes_ff - len_ff;
         end
      end else if (unavail_ff) begin
         verdict = V_UNAVAILABLE;
      end else if (!pass_ff) begin
         verdict = V_SAMPLED_OUT;
      end else if (len_ff == '0 || len_ff > max_bytes_ff ||
                   credit_msgs_ff >= max_msgs_ff ||
                   credit_bytes_ff > max_bytes_ff - len_ff) begin
         verdict = V_FULL;
      end else begin
         verdict         = V_ACCEPTED;
         credit_msgs_in  = credit_msgs_ff + MSG_W'(1);
         credit_bytes_in = credit_bytes_ff + len_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      work_in      = work_ff;
      opnd_in      = opnd_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      unavail_in   = unavail_ff;
      pass_in      = pass_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_tuser;
               len_in     = req_tdata;
               unavail_in = !open_ff || blocked_ff;
               pass_in    = (cutoff_ff == SAMPLE_CUTOFF_RST);
               phase_in   = 2'd0;
               step_in    = 2'd0;
               work_in    = seq_ff + MIX_GOLDEN;
               if (req_tuser == CMD_SUBMIT && open_ff && !blocked_ff &&
                   cutoff_ff != '0 && cutoff_ff != SAMPLE_CUTOFF_RST) begin
                  seq_in   = seq_ff + 64'd1;
                  state_in = ST_XFORM;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_XFORM: begin
            work_in = '0;
            step_in = 2'd0;
            case (phase_ff)
               2'd0: begin
                  opnd_in  = work_ff ^ (work_ff >> MIX_SHIFT_A);
                  state_in = ST_MUL;
               end
               2'd1: begin
                  opnd_in  = work_ff ^ (work_ff >> MIX_SHIFT_B);
                  state_in = ST_MUL;
               end
               default: begin
                  pass_in  = (hash_val <= cutoff_ff);
                  state_in = ST_DECIDE;
               end
            endcase
         end
         ST_MUL: begin
            if (step_ff == 2'd0) begin
               work_in = work_ff + mul_p;
            end else begin
               work_in = work_ff + {mul_p[31:0], 32'b0};
            end
            if (step_ff == 2'd2) begin
               phase_in = phase_ff + 2'd1;
               state_in = ST_XFORM;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, credit_bytes_in, credit_msgs_in, verdict};
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         seq_ff          <= '0;
         credit_msgs_ff  <= '0;
         credit_bytes_ff <= '0;
         max_msgs_ff     <= MAX_MESSAGES_RST;
         max_bytes_ff    <= MAX_BYTES_RST;
         cutoff_ff       <= SAMPLE_CUTOFF_RST;
         blocked_ff      <= 1'b0;
         open_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
         if (state_ff == ST_DECIDE && out_free) begin
            credit_msgs_ff  <= credit_msgs_in;
            credit_bytes_ff <= credit_bytes_in;
         end
         if (csr_wen) begin
            case (csr_addr)
               REG_MAX_MESSAGES:  max_msgs_ff  <= csr_wdata[MSG_W-1:0];
               REG_MAX_BYTES:     max_bytes_ff <= csr_wdata[BYTE_W-1:0];
               REG_SAMPLE_CUTOFF: cutoff_ff    <= csr_wdata;
               REG_BLOCKED:       blocked_ff   <= csr_wdata[0];
               REG_OPEN:          open_ff      <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      step_ff     <= step_in;
      work_ff     <= work_in;
      opnd_ff     <= opnd_in;
      cmd_ff      <= cmd_in;
      len_ff      <= len_in;
      unavail_ff  <= unavail_in;
      pass_ff     <= pass_in;
      rsp_data_ff <= rsp_data_in;
   end

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while busy");

   // counter advances only on an accepted submission
   a_seq_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(seq_ff))
      else $error("sequence counter moved without a request");

   // credit changes only when a result is produced
   a_credit_at_decide: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_DECIDE && out_free) |=>
         $stable(credit_msgs_ff) && $stable(credit_bytes_ff))
      else $error("credit changed outside decision");

   // partial product index stays in range
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (step_ff <= 2'd2 && phase_ff <= 2'd1))
      else $error("multiply step out of range");

endmodule

// File: verif/sampled_credit_admission_gate_unit_tb.sv
// ----------------------------------------------------------------------------
// sampled_credit_admission_gate_unit_tb
// Self-checking bench for the admission gate. A short directed run covers
// closed, blocked, sampled-out, zero-length, oversize and over-limit
// submissions and good and bad releases. Random phases with different limits
// and cutoffs follow, most under random stalls on both streams. Every result is
// compared field by field with a local model of the gate.
// ----------------------------------------------------------------------------
module sampled_credit_admission_gate_unit_tb;
   import scag_pkg::*;

   typedef struct packed {
      logic        command;
      logic [31:0] message_bytes;
   } gate_request_t;

   typedef struct packed {
      verdict_type       verdict;
      logic [MSG_W-1:0]  held_messages;
      logic [BYTE_W-1:0] held_bytes;
   } gate_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   csr_addr_type          csr_addr = REG_MAX_MESSAGES;
   logic [63:0]           csr_wdata = '0;

   // gate model: registers and credit state
   logic [MSG_W-1:0]  lim_messages = MAX_MESSAGES_RST;
   logic [BYTE_W-1:0] lim_bytes = MAX_BYTES_RST;
   logic [63:0]       model_cutoff = SAMPLE_CUTOFF_RST;
   logic              gate_blocked = 1'b0;
   logic              gate_open = 1'b0;
   logic [63:0]       hash_sequence = '0;
   logic [MSG_W-1:0]  held_msgs = '0;
   logic [BYTE_W-1:0] held_byte_count = '0;

   gate_request_t queued_requests[$];
   gate_result_t  predicted_results[$];
   logic [31:0]   submitted_lengths[$];
   logic          request_taken = 1'b0;
   int unsigned   outstanding = 0;
   int unsigned   send_idle_pct = 31;
   int unsigned   recv_idle_pct = 57;
   int unsigned   failures = 0;

   sampled_credit_admission_gate_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [63:0] splitmix_hash(input logic [63:0] seed);
      logic [63:0] x;
      x = seed + MIX_GOLDEN;
      x = (x ^ (x >> MIX_SHIFT_A)) * MIX_MUL_A;
      x = (x ^ (x >> MIX_SHIFT_B)) * MIX_MUL_B;
      return x ^ (x >> MIX_SHIFT_C);
   endfunction

   task automatic predict_admission(input logic command, input logic [31:0] len);
      gate_result_t res;
      logic         kept;
      if (command == CMD_SUBMIT) begin
         if (!gate_open || gate_blocked) begin
            res.verdict = V_UNAVAILABLE;
         end else begin
            kept = 1'b1;
            if (model_cutoff == '0) begin
               kept = 1'b0;
            end else if (model_cutoff != '1) begin
               // only a real hash advances the sequence
               kept = splitmix_hash(hash_sequence) <= model_cutoff;
               hash_sequence = hash_sequence + 64'd1;
            end
            if (!kept) begin
               res.verdict = V_SAMPLED_OUT;
            end else if (len == '0 || len > lim_bytes || held_msgs >= lim_messages ||
                         held_byte_count > lim_bytes - len) begin
               res.verdict = V_FULL;
            end else begin
               held_msgs = held_msgs + 31'd1;
               held_byte_count = held_byte_count + len;
               res.verdict = V_ACCEPTED;
            end
         end
      end else if (held_msgs == '0 || held_byte_count < len) begin
         res.verdict = V_RELEASE_ERROR;
      end else begin
         held_msgs = held_msgs - 31'd1;
         held_byte_count = held_byte_count - len;
         res.verdict = V_RELEASED;
      end
      res.held_messages = held_msgs;
      res.held_bytes = held_byte_count;
      predicted_results.insert(predicted_results.size(), res);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || request_taken) begin
         request_taken = 1'b0;
         if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            gate_request_t nxt;
            nxt = queued_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.command;
            req_tdata <= nxt.message_bytes;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      gate_result_t got;
      gate_result_t want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_admission(req_tuser, req_tdata);
            request_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outstanding > 0)
               outstanding--;
            got.verdict = rsp_tdata[2:0];
            got.held_messages = rsp_tdata[33:3];
            got.held_bytes = rsp_tdata[65:34];
            if (predicted_results.size() == 0) begin
               $error("unexpected result: verdict %0d", got.verdict);
               failures++;
            end else begin
               want = predicted_results.pop_front();
               if (got.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                  failures++;
               end
               if (got.held_messages !== want.held_messages) begin
                  $error("held_messages: expected %0d, got %0d",
                         want.held_messages, got.held_messages);
                  failures++;
               end
               if (got.held_bytes !== want.held_bytes) begin
                  $error("held_bytes: expected %0d, got %0d",
                         want.held_bytes, got.held_bytes);
                  failures++;
               end
            end
         end
      end
   end

   task automatic queue_request(input logic command, input logic [31:0] len);
      gate_request_t req;
      req.command = command;
      req.message_bytes = len;
      outstanding++;
      queued_requests.insert(queued_requests.size(), req);
   endtask

   // every queued request has had its result taken
   task automatic wait_drained();
      while (outstanding > 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input csr_addr_type idx, input logic [63:0] value);
      wait_drained();
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         REG_MAX_MESSAGES:  lim_messages = value[MSG_W-1:0];
         REG_MAX_BYTES:     lim_bytes = value[BYTE_W-1:0];
         REG_SAMPLE_CUTOFF: model_cutoff = value;
         REG_BLOCKED:       gate_blocked = value[0];
         REG_OPEN:          gate_open = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_gate(input logic [30:0] msgs, input logic [31:0] bytes,
                               input logic [63:0] cutoff, input logic blk,
                               input logic opn);
      write_reg(REG_MAX_MESSAGES, {33'd0, msgs});
      write_reg(REG_MAX_BYTES, {32'd0, bytes});
      write_reg(REG_SAMPLE_CUTOFF, cutoff);
      write_reg(REG_BLOCKED, {63'd0, blk});
      write_reg(REG_OPEN, {63'd0, opn});
   endtask

   // mostly submit/release pairs of plausible size, some raw noise
   task automatic run_random_phase(input int unsigned count, input int unsigned len_cap);
      logic [31:0] len;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = ($urandom_range(49) == 0) ? 32'd0 : $urandom_range(len_cap, 1);
            submitted_lengths.insert(submitted_lengths.size(), len);
            queue_request(CMD_SUBMIT, len);
         end else if (pick < 90) begin
            if (submitted_lengths.size() > 0)
               len = submitted_lengths.pop_front();
            else
               len = $urandom_range(len_cap);
            queue_request(CMD_RELEASE, len);
         end else begin
            queue_request(logic'($urandom_range(1)), $urandom());
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // gate closed after reset
      queue_request(CMD_SUBMIT, 32'd100);
      queue_request(CMD_RELEASE, 32'd0);

      write_reg(REG_OPEN, 64'd1);
      queue_request(CMD_SUBMIT, 32'd0);
      queue_request(CMD_SUBMIT, 32'd1);
      queue_request(CMD_SUBMIT, 32'hFFFF_FFFF);
      queue_request(CMD_SUBMIT, MAX_BYTES_RST - 32'd1);
      queue_request(CMD_SUBMIT, 32'd1);
      queue_request(CMD_RELEASE, 32'hFFFF_FFFF);
      queue_request(CMD_RELEASE, 32'd1);

      // releases still pass while blocked
      write_reg(REG_BLOCKED, 64'd1);
      queue_request(CMD_SUBMIT, 32'd5);
      queue_request(CMD_RELEASE, MAX_BYTES_RST - 32'd1);

      write_reg(REG_BLOCKED, 64'd0);
      write_reg(REG_MAX_MESSAGES, 64'd1);
      queue_request(CMD_SUBMIT, 32'd10);
      queue_request(CMD_SUBMIT, 32'd10);

      // limit dropped under held credit
      write_reg(REG_MAX_MESSAGES, 64'd0);
      queue_request(CMD_SUBMIT, 32'd1);
      queue_request(CMD_RELEASE, 32'd10);

      write_reg(REG_SAMPLE_CUTOFF, 64'd0);
      queue_request(CMD_SUBMIT, 32'd7);

      program_gate(31'h7FFF_FFFF, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
      repeat (3) queue_request(CMD_SUBMIT, 32'hFFFF_FFFF);
      queue_request(CMD_SUBMIT, 32'd0);

      write_reg(REG_OPEN, 64'd0);
      queue_request(CMD_SUBMIT, 32'd3);
      queue_request(CMD_RELEASE, 32'd0);

      program_gate(31'd16, 32'd8192, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
      run_random_phase(160, 1024);
      program_gate(31'($urandom_range(8, 1)), $urandom_range(4096, 1),
                   {$urandom(), $urandom()}, 1'b0, 1'b1);
      run_random_phase(160, 512);

      wait_drained();
      send_idle_pct = 57;
      recv_idle_pct = 31;
      program_gate(31'h7FFF_FFFF, 32'hFFFF_FFFF, '1, 1'b0, 1'b1);
      run_random_phase(160, 32'hFFFF_FFFF);
      program_gate(31'($urandom_range(6, 1)), 32'd1 << 20, {$urandom(), $urandom()},
                   logic'($urandom_range(3) == 0), 1'b1);
      run_random_phase(160, 4096);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_gate(31'd64, 32'd65536, {1'b0, $urandom(), 31'($urandom())}, 1'b0, 1'b1);
      run_random_phase(160, 2048);
      // held credit now likely above the new limits
      program_gate(31'd2, 32'd100, 64'hC000_0000_0000_0000, 1'b0, 1'b1);
      run_random_phase(150, 64);

      wait_drained();
      repeat (20) @(negedge clock);
      if (failures == 0 && predicted_results.size() == 0)
         $display("sampled_credit_admission_gate_unit_tb OK");
      else
         $display("sampled_credit_admission_gate_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("sampled_credit_admission_gate_unit_tb NOT OK");
      $finish;
   end

endmodule

// File: sim.f
hdl/scag_pkg.sv
hdl/sampled_credit_admission_gate_unit.sv
verif/sampled_credit_admission_gate_unit_tb.sv
